>>> src/encoder_pulse_interval_tracker_macros.svh
// assertion macros for the encoder pulse interval tracker
// expects clk and rst_n in the scope that uses them
`ifndef ENCODER_PULSE_INTERVAL_TRACKER_MACROS_SVH
`define ENCODER_PULSE_INTERVAL_TRACKER_MACROS_SVH

// same-cycle implication, held off during reset
`define EPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define EPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ept_pkg.sv
// shared types and constants for the encoder pulse interval tracker
// no dependencies
`timescale 1ns / 1ps

package ept_pkg;

  localparam int TS_W       = 64;
  localparam int CNT_W      = 32;
  localparam int TGT_W      = 16;
  localparam int REFR_W     = 20;
  localparam int NUM_CH     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  typedef logic [TS_W-1:0]   ts_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TGT_W-1:0]  tgt_t;
  typedef logic [REFR_W-1:0] refr_t;

  typedef enum logic {
    CMD_EDGE    = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CALIBRATION_ON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TARGET_EDGES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REFRACTORY_US  = 2'd2;

  localparam refr_t REFRACTORY_RESET = 20'd10000;

  typedef struct packed {
    cmd_t       command;
    logic       channel;
    ts_t        timestamp_us;
  } ept_item_t;

  typedef struct packed {
    logic       calibration_on;
    tgt_t       target_edges;
    refr_t      refractory_us;
  } ept_cfg_t;

  typedef struct packed {
    ts_t  [NUM_CH-1:0] last_time;
    ts_t  [NUM_CH-1:0] sum;
    cnt_t [NUM_CH-1:0] count;
    cnt_t              edge_count;
    ts_t               cal_first;
    ts_t               cal_last;
  } ept_state_t;

  typedef struct packed {
    logic accepted;
    ts_t  interval_us;
    ts_t  channel_sum_us;
    cnt_t channel_count;
    cnt_t edge_count;
    ts_t  cal_start_us;
    ts_t  cal_end_us;
    logic cal_done;
  } ept_result_t;

endpackage

>>> src/ept_if.sv
// valid/ready channel interfaces: edge events in, results out, register writes
// depends on ept_pkg
`timescale 1ns / 1ps

interface ept_in_if;
  import ept_pkg::*;
  logic valid;
  logic ready;
  logic command;
  logic channel;
  ts_t  timestamp_us;

  modport source (output valid, command, channel, timestamp_us, input ready);
  modport sink   (input valid, command, channel, timestamp_us, output ready);
endinterface

interface ept_out_if;
  import ept_pkg::*;
  logic valid;
  logic ready;
  logic accepted;
  ts_t  interval_us;
  ts_t  channel_sum_us;
  cnt_t channel_count;
  cnt_t edge_count;
  ts_t  cal_start_us;
  ts_t  cal_end_us;
  logic cal_done;

  modport source (output valid, accepted, interval_us, channel_sum_us, channel_count,
                  edge_count, cal_start_us, cal_end_us, cal_done, input ready);
  modport sink   (input valid, accepted, interval_us, channel_sum_us, channel_count,
                  edge_count, cal_start_us, cal_end_us, cal_done, output ready);
endinterface

interface ept_cfg_if;
  import ept_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/encoder_pulse_interval_tracker.sv
// top level of the encoder pulse interval tracker: input stage, state, result stage
// depends on ept_pkg, ept_if, ept_update and encoder_pulse_interval_tracker_macros.svh
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  in_ch   | in  | command, channel, timestamp_us
//  out_ch  | out | accepted, interval_us, channel_sum_us, channel_count,
//          |     | edge_count, cal_start_us, cal_end_us, cal_done
//  cfg_ch  | in  | index, data (register write, always ready)
//
// one beat per cycle while the result is not stalled; each beat goes through the input
// register, then the state update and the result register
// rst_n is synchronous, active low; it clears state and both valid flags and loads config defaults
// a stalled result holds the input stage, which then drops in_ch.ready
`timescale 1ns / 1ps
`include "encoder_pulse_interval_tracker_macros.svh"

module encoder_pulse_interval_tracker (
  input logic    clk,
  input logic    rst_n,
  ept_in_if.sink    in_ch,
  ept_out_if.source out_ch,
  ept_cfg_if.sink   cfg_ch
);
  import ept_pkg::*;

  // input stage
  logic        s1_valid_r, s1_valid_nxt;
  ept_item_t   s1_item_r;
  logic        in_fire;
  logic        s1_fire;

  // configuration registers
  ept_cfg_t    cfg_r, cfg_nxt;

  // tracker state
  ept_state_t  state_r, state_nxt;

  // result stage
  logic        out_valid_r, out_valid_nxt;
  ept_result_t out_res_r, res_nxt;

  // the input stage moves on when the result stage is empty or being drained
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.command      <= cmd_t'(in_ch.command);
      s1_item_r.channel      <= in_ch.channel;
      s1_item_r.timestamp_us <= in_ch.timestamp_us;
    end
    if (s1_fire) begin
      out_res_r <= res_nxt;
    end
  end

  // register writes; an unknown index is dropped
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_IDX_CALIBRATION_ON: cfg_nxt.calibration_on = cfg_ch.data[0];
        CFG_IDX_TARGET_EDGES:   cfg_nxt.target_edges   = cfg_ch.data[TGT_W-1:0];
        CFG_IDX_REFRACTORY_US:  cfg_nxt.refractory_us  = cfg_ch.data[REFR_W-1:0];
        default:                cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.calibration_on <= 1'b0;
      cfg_r.target_edges   <= '0;
      cfg_r.refractory_us  <= REFRACTORY_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // debounce, accumulate and calibration counting for the event in the input stage
  ept_update u_update (
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // state only moves when an event leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  // result beat
  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = out_res_r.accepted;
  assign out_ch.interval_us    = out_res_r.interval_us;
  assign out_ch.channel_sum_us = out_res_r.channel_sum_us;
  assign out_ch.channel_count  = out_res_r.channel_count;
  assign out_ch.edge_count     = out_res_r.edge_count;
  assign out_ch.cal_start_us   = out_res_r.cal_start_us;
  assign out_ch.cal_end_us     = out_res_r.cal_end_us;
  assign out_ch.cal_done       = out_res_r.cal_done;

  // checks
  `EPT_ASSERT_NEXT(a_restart_clears, s1_fire && s1_item_r.command == CMD_RESTART, state_r.edge_count == '0 && state_r.count[0] == '0 && state_r.count[1] == '0, "restart did not clear counts")
  `EPT_ASSERT_NEXT(a_cal_edge_step, s1_fire && s1_item_r.command == CMD_EDGE && cfg_r.calibration_on, state_r.edge_count == $past(state_r.edge_count) + CNT_W'(1), "calibration edge count did not step")
  `EPT_ASSERT_NEXT(a_state_holds, !s1_fire, $stable(state_r), "state moved without an event")
  `EPT_ASSERT_NOW(a_debounce, s1_fire && s1_item_r.command == CMD_EDGE && !cfg_r.calibration_on && res_nxt.accepted, res_nxt.interval_us >= TS_W'(cfg_r.refractory_us), "edge accepted inside refractory time")
  `EPT_ASSERT_NEXT(a_stage_holds, s1_valid_r && !s1_fire, s1_valid_r && $stable(s1_item_r), "stalled event lost")

endmodule

>>> src/ept_update.sv
// next-state and result logic for one event against the tracker state
// depends on ept_pkg
`timescale 1ns / 1ps

module ept_update (
  input  ept_pkg::ept_item_t   item,
  input  ept_pkg::ept_cfg_t    cfg,
  input  ept_pkg::ept_state_t  st,
  output ept_pkg::ept_state_t  st_nxt,
  output ept_pkg::ept_result_t res
);
  import ept_pkg::*;

  ts_t  diff;
  logic acc;
  ts_t  interval;

  assign diff = item.timestamp_us - st.last_time[item.channel];

  always_comb begin
    st_nxt   = st;
    acc      = 1'b0;
    interval = '0;
    if (item.command == CMD_RESTART) begin
      for (int i = 0; i < NUM_CH; i++) begin
        st_nxt.sum[i]       = '0;
        st_nxt.count[i]     = '0;
        st_nxt.last_time[i] = item.timestamp_us;
      end
      st_nxt.edge_count = '0;
    end else if (cfg.calibration_on) begin
      // every edge counts, channel ignored
      if (st.edge_count == '0) begin
        st_nxt.cal_first = item.timestamp_us;
      end
      if (st.edge_count == CNT_W'(cfg.target_edges)) begin
        st_nxt.cal_last = item.timestamp_us;
      end
      st_nxt.edge_count = st.edge_count + CNT_W'(1);
      acc               = 1'b1;
    end else begin
      interval = diff;
      if (diff >= TS_W'(cfg.refractory_us)) begin
        st_nxt.last_time[item.channel] = item.timestamp_us;
        st_nxt.sum[item.channel]       = st.sum[item.channel] + diff;
        st_nxt.count[item.channel]     = st.count[item.channel] + CNT_W'(1);
        acc                            = 1'b1;
      end
    end
  end

  always_comb begin
    res.accepted       = acc;
    res.interval_us    = interval;
    res.channel_sum_us = st_nxt.sum[item.channel];
    res.channel_count  = st_nxt.count[item.channel];
    res.edge_count     = st_nxt.edge_count;
    res.cal_start_us   = st_nxt.cal_first;
    res.cal_end_us     = st_nxt.cal_last;
    res.cal_done       = (st_nxt.edge_count > CNT_W'(cfg.target_edges));
  end

endmodule
